[rtl/tfa_pkg.sv]
// Shared types and constants for the temporal frame averager.
// Used by every module of the block; depends on nothing.
package tfa_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 16;
    localparam int MAX_PIXELS = 1048576;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int MAX_FRAMES = 256;
    localparam int FRAMES_W   = $clog2(MAX_FRAMES) + 1;
    localparam int FPOS_W     = $clog2(MAX_FRAMES);
    localparam int PCOUNT_W   = ADDR_W + 1;
    localparam int CFG_DATA_W = PCOUNT_W;
    localparam int CFG_ADDR_W = 2;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [PIX_W-1:0] AVG_MAX = 8'd255;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;    // take the input word, read the running sum
        logic acc;       // write the new sum, advance the positions
        logic out_load;  // move the quotient into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_frame;  // current frame is the last of the run
        logic div_busy;    // divider still iterating
        logic out_free;    // output register can take a word this cycle
    } t_dp_sts;

endpackage

[rtl/tfa_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tfa_pkg for widths.
module tfa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tfa_pkg::SUM_W-1:0]     i_dividend,
    input  logic [tfa_pkg::FRAMES_W-1:0]  i_divisor,
    output logic                          o_busy,
    output logic [tfa_pkg::SUM_W-1:0]     o_quotient
);

    logic                             r_busy;
    logic [tfa_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [tfa_pkg::SUM_W-1:0]        r_q;
    logic [tfa_pkg::FRAMES_W-1:0]     r_rem;
    logic [tfa_pkg::FRAMES_W:0]       w_trial;
    logic                             w_ge;
    logic [tfa_pkg::FRAMES_W:0]       w_diff;

    // shift in the next dividend bit and try a subtraction
    always_comb begin
        w_trial = {r_rem, r_q[tfa_pkg::SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == tfa_pkg::DIV_CNT_W'(tfa_pkg::SUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[tfa_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[tfa_pkg::FRAMES_W-1:0] : w_trial[tfa_pkg::FRAMES_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule

[rtl/tfa_datapath.sv]
// Datapath: configuration, positions, per-pixel sum memory, divider, output word.
// Depends on tfa_pkg and tfa_div.
module tfa_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tfa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [tfa_pkg::PIX_W-1:0]         i_pixel,
    input  tfa_pkg::t_dp_cmd                  i_cmd,
    output tfa_pkg::t_dp_sts                  o_sts,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [tfa_pkg::PIX_W-1:0]         o_avg_pixel,
    output logic                              o_frame_last
);

    logic [tfa_pkg::SUM_W-1:0]     r_mem [tfa_pkg::MAX_PIXELS];
    logic [tfa_pkg::SUM_W-1:0]     r_rd_sum;
    logic [tfa_pkg::PIX_W-1:0]     r_pix;
    logic [tfa_pkg::FRAMES_W-1:0]  r_frames;
    logic [tfa_pkg::FPOS_W-1:0]    r_frame_last;
    logic [tfa_pkg::ADDR_W-1:0]    r_pix_last;
    logic [tfa_pkg::ADDR_W-1:0]    r_pos;
    logic [tfa_pkg::FPOS_W-1:0]    r_fpos;
    logic                          r_div_last;
    logic                          r_out_valid;
    logic [tfa_pkg::PIX_W-1:0]     r_out_avg;
    logic                          r_out_last;

    logic [tfa_pkg::FRAMES_W-1:0]  n_frames;
    logic [tfa_pkg::PCOUNT_W-1:0]  n_pixels;
    logic [tfa_pkg::FRAMES_W-1:0]  w_fval;
    logic [tfa_pkg::PCOUNT_W-1:0]  w_pval;
    logic                          w_first;
    logic                          w_last_frame;
    logic                          w_last_pix;
    logic [tfa_pkg::SUM_W:0]       w_sum_raw;
    logic [tfa_pkg::SUM_W-1:0]     w_sum;
    logic                          w_div_busy;
    logic [tfa_pkg::SUM_W-1:0]     w_quot;
    logic [tfa_pkg::PIX_W-1:0]     w_avg;

    // clamp register writes to their usable range
    always_comb begin
        w_fval = i_cfg_data[tfa_pkg::FRAMES_W-1:0];
        w_pval = i_cfg_data[tfa_pkg::PCOUNT_W-1:0];
        if (w_fval == '0) begin
            n_frames = tfa_pkg::FRAMES_W'(1);
        end else if (w_fval > tfa_pkg::FRAMES_W'(tfa_pkg::MAX_FRAMES)) begin
            n_frames = tfa_pkg::FRAMES_W'(tfa_pkg::MAX_FRAMES);
        end else begin
            n_frames = w_fval;
        end
        if (w_pval == '0) begin
            n_pixels = tfa_pkg::PCOUNT_W'(1);
        end else if (w_pval > tfa_pkg::PCOUNT_W'(tfa_pkg::MAX_PIXELS)) begin
            n_pixels = tfa_pkg::PCOUNT_W'(tfa_pkg::MAX_PIXELS);
        end else begin
            n_pixels = w_pval;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames     <= tfa_pkg::FRAMES_W'(1);
            r_frame_last <= '0;
            r_pix_last   <= tfa_pkg::ADDR_W'(tfa_pkg::MAX_PIXELS - 1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tfa_pkg::CFG_FRAME_COUNT: begin
                    r_frames     <= n_frames;
                    r_frame_last <= tfa_pkg::FPOS_W'(n_frames - 1'b1);
                end
                tfa_pkg::CFG_PIXEL_COUNT: begin
                    r_pix_last <= tfa_pkg::ADDR_W'(n_pixels - 1'b1);
                end
                default: begin
                end
            endcase
        end
    end

    assign w_first      = (r_fpos == '0);
    assign w_last_frame = (r_fpos == r_frame_last);
    assign w_last_pix   = (r_pos == r_pix_last);

    // new running sum, saturated to the sum width
    always_comb begin
        w_sum_raw = {1'b0, (w_first ? tfa_pkg::SUM_W'(0) : r_rd_sum)}
                    + (tfa_pkg::SUM_W + 1)'(r_pix);
        w_sum     = w_sum_raw[tfa_pkg::SUM_W] ? '1 : w_sum_raw[tfa_pkg::SUM_W-1:0];
    end

    // pixel and frame positions; any register write restarts the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fpos <= '0;
        end else if (i_cfg_we) begin
            r_pos  <= '0;
            r_fpos <= '0;
        end else if (i_cmd.acc) begin
            if (w_last_pix) begin
                r_pos  <= '0;
                r_fpos <= w_last_frame ? '0 : r_fpos + 1'b1;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // sum memory: read on accept, write back in the cycle after
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_sum <= r_mem[r_pos];
            r_pix    <= i_pixel;
        end
        if (i_cmd.acc) begin
            r_mem[r_pos] <= w_sum;
            r_div_last   <= w_last_pix;
        end
    end

    tfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.acc && w_last_frame),
        .i_dividend (w_sum),
        .i_divisor  (r_frames),
        .o_busy     (w_div_busy),
        .o_quotient (w_quot)
    );

    assign w_avg = (w_quot > tfa_pkg::SUM_W'(tfa_pkg::AVG_MAX)) ?
                   tfa_pkg::AVG_MAX : w_quot[tfa_pkg::PIX_W-1:0];

    // output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_avg  <= w_avg;
            r_out_last <= r_div_last;
        end
    end

    always_comb begin
        o_sts.last_frame = w_last_frame;
        o_sts.div_busy   = w_div_busy;
        o_sts.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_avg_pixel  = r_out_avg;
    assign o_frame_last = r_out_last;

endmodule

[rtl/tfa_ctrl.sv]
// Controller state machine: accept and accumulate per word, divide in the last frame.
// Depends on tfa_pkg for the state and command types.
module tfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  tfa_pkg::t_dp_sts i_sts,
    output tfa_pkg::t_dp_cmd o_cmd
);

    tfa_pkg::t_state r_state;
    tfa_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            tfa_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = tfa_pkg::ST_ACC;
                end
            end
            tfa_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last_frame ? tfa_pkg::ST_DIV : tfa_pkg::ST_IDLE;
            end
            tfa_pkg::ST_DIV: begin
                if (!i_sts.div_busy && i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/temporal_frame_averager.sv]
// Temporal frame averager: takes 8-bit grey pixels of frame_count frames of
// pixel_count pixels each, keeps a 16-bit running sum per pixel position in an
// on-chip memory (first frame of a run overwrites, later frames add), and in
// the last frame of the run emits sum / frame_count, saturated to 255, with
// tlast on the final pixel. Outside the last frame each pixel takes a sum memory
// read, then a write back; in the last frame it also waits on the 16-step
// bit-serial divider and a free output. The sum memory needs no clearing pass
// after reset. Any configuration write restarts the run.
module temporal_frame_averager (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tfa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] pixel
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [7:0]                        o_m_tdata,   // [7:0] avg_pixel
    output logic                              o_m_tlast    // frame_last
);

    tfa_pkg::t_dp_cmd w_cmd;
    tfa_pkg::t_dp_sts w_sts;

    tfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tfa_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_pixel      (i_s_tdata),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_avg_pixel  (o_m_tdata),
        .o_frame_last (o_m_tlast)
    );

    // an accepted word is always accumulated in the next cycle
    a_acc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> w_cmd.acc)
        else $error("accepted word not accumulated");

    // a quotient is loaded only when the divider is done and the output is free
    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!w_sts.div_busy && w_sts.out_free))
        else $error("output loaded while divider busy or output full");

    // no word is taken while a division is in flight
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> !w_sts.div_busy)
        else $error("word accepted during division");

endmodule

[bench/temporal_frame_averager_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for temporal_frame_averager: a directed stimulus table, then
// random runs of frames, every averaged word checked against the table or a predictor.
// Depends on tfa_pkg and the averager RTL.
module temporal_frame_averager_test;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int IDLE_PCT      = 18;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 32;

    // indexes past the register list; a write there only restarts the run
    localparam logic [tfa_pkg::CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tfa_pkg::CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [tfa_pkg::CFG_DATA_W-1:0] CFG_ONES    = '1;

    typedef struct packed {
        logic [tfa_pkg::PIX_W-1:0] avg;
        logic                      last;
    } t_avg_word;

    typedef enum logic {
        ROW_CFG,
        ROW_PIX
    } t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [tfa_pkg::CFG_ADDR_W-1:0] addr;
        logic [tfa_pkg::CFG_DATA_W-1:0] data;
        logic [tfa_pkg::PIX_W-1:0]      pix;
        logic                           known;
        t_avg_word                      known_word;
    } t_stim_row;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [tfa_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [tfa_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [7:0]                     i_s_tdata  = '0;   // [7:0] pixel
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [7:0]                     o_m_tdata;         // [7:0] avg_pixel
    logic                           o_m_tlast;         // frame_last

    // predictor state and register copies
    logic [tfa_pkg::FRAMES_W-1:0]   frames_reg = tfa_pkg::FRAMES_W'(1);
    logic [tfa_pkg::PCOUNT_W-1:0]   pixels_reg = tfa_pkg::PCOUNT_W'(tfa_pkg::MAX_PIXELS);
    logic [tfa_pkg::ADDR_W-1:0]     pixel_pos  = '0;
    logic [tfa_pkg::FPOS_W-1:0]     frame_pos  = '0;
    bit   [tfa_pkg::SUM_W-1:0]      pixel_sum_store [tfa_pkg::MAX_PIXELS];

    t_avg_word                      pending_avgs [$];
    t_stim_row                      directed_rows [DIRECTED_ROWS];
    int                             fail_count   = 0;
    bit                             steady       = 1'b0;
    bit                             hold_request = 1'b0;

    temporal_frame_averager u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // clamp the frame count into 1..MAX_FRAMES
    function automatic logic [tfa_pkg::FRAMES_W-1:0] eff_frames(
            input logic [tfa_pkg::FRAMES_W-1:0] word);
        if (word == '0) return tfa_pkg::FRAMES_W'(1);
        if (word > tfa_pkg::FRAMES_W'(tfa_pkg::MAX_FRAMES))
            return tfa_pkg::FRAMES_W'(tfa_pkg::MAX_FRAMES);
        return word;
    endfunction

    // clamp the pixel count into 1..MAX_PIXELS
    function automatic logic [tfa_pkg::PCOUNT_W-1:0] eff_pixels(
            input logic [tfa_pkg::PCOUNT_W-1:0] word);
        if (word == '0) return tfa_pkg::PCOUNT_W'(1);
        if (word > tfa_pkg::PCOUNT_W'(tfa_pkg::MAX_PIXELS))
            return tfa_pkg::PCOUNT_W'(tfa_pkg::MAX_PIXELS);
        return word;
    endfunction

    // Take one pixel into the sums; return the averaged word in the last frame.
    function automatic void advance_average(input logic [tfa_pkg::PIX_W-1:0] pix,
                                            output bit produced, output t_avg_word word);
        logic [tfa_pkg::FRAMES_W-1:0] frames;
        logic [tfa_pkg::PCOUNT_W-1:0] pixels;
        logic [tfa_pkg::PCOUNT_W-1:0] pos;
        logic [tfa_pkg::SUM_W:0]      pix_ext;
        logic [tfa_pkg::SUM_W:0]      sum;
        logic [tfa_pkg::SUM_W:0]      quot;
        frames  = eff_frames(frames_reg);
        pixels  = eff_pixels(pixels_reg);
        pix_ext = (tfa_pkg::SUM_W + 1)'(pix);
        pos = {1'b0, pixel_pos};
        if (pos >= pixels) pos = '0;
        if ({1'b0, frame_pos} >= frames) frame_pos = '0;

        // first frame of a run overwrites, later frames add
        if (frame_pos == '0) begin
            sum = pix_ext;
        end else begin
            sum = {1'b0, pixel_sum_store[pos[tfa_pkg::ADDR_W-1:0]]} + pix_ext;
        end
        if (sum[tfa_pkg::SUM_W]) sum = {1'b0, {tfa_pkg::SUM_W{1'b1}}};
        pixel_sum_store[pos[tfa_pkg::ADDR_W-1:0]] = sum[tfa_pkg::SUM_W-1:0];

        produced = ({1'b0, frame_pos} == frames - 1'b1);
        word = '0;
        if (produced) begin
            quot = sum / (tfa_pkg::SUM_W + 1)'(frames);
            if (quot > (tfa_pkg::SUM_W + 1)'(tfa_pkg::AVG_MAX))
                quot = (tfa_pkg::SUM_W + 1)'(tfa_pkg::AVG_MAX);
            word.avg  = quot[tfa_pkg::PIX_W-1:0];
            word.last = (pos == pixels - 1'b1);
        end

        // advance pixel, then frame, position
        pos = pos + 1'b1;
        if (pos >= pixels) begin
            pixel_pos = '0;
            frame_pos = ({1'b0, frame_pos} + 1'b1 >= frames) ? '0 : frame_pos + 1'b1;
        end else begin
            pixel_pos = pos[tfa_pkg::ADDR_W-1:0];
        end
    endfunction

    // mostly random grey values, with the extremes pulled in often
    function automatic logic [tfa_pkg::PIX_W-1:0] pick_pixel();
        int draw;
        draw = int'($urandom_range(99));
        if (draw < 10) return '0;
        if (draw < 20) return '1;
        return tfa_pkg::PIX_W'($urandom_range(255));
    endfunction

    // Offer one pixel word, hold it until taken, then record what it should yield.
    task automatic send_pixel(input logic [tfa_pkg::PIX_W-1:0] pix, input logic known,
                              input t_avg_word known_word);
        bit        produced;
        t_avg_word word;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_tready);
        advance_average(pix, produced, word);
        if (known) begin
            pending_avgs.push_back(known_word);
        end else if (produced) begin
            pending_avgs.push_back(word);
        end
    endtask

    // Drop valid, drain all expected words, then let the pipeline run dry.
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_avgs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register for one cycle; every write restarts the run.
    task automatic write_reg(input logic [tfa_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [tfa_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        if (addr == tfa_pkg::CFG_FRAME_COUNT) begin
            frames_reg = data[tfa_pkg::FRAMES_W-1:0];
        end else if (addr == tfa_pkg::CFG_PIXEL_COUNT) begin
            pixels_reg = data[tfa_pkg::PCOUNT_W-1:0];
        end
        pixel_pos = '0;
        frame_pos = '0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Check each accepted output word against the oldest expectation.
    always @(posedge i_clk) begin : check_avg
        t_avg_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_avgs.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected word: avg %0d last %0b", o_m_tdata, o_m_tlast);
            end else begin
                want = pending_avgs.pop_front();
                if (o_m_tdata !== want.avg || o_m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch: expected avg %0d last %0b, got avg %0d last %0b",
                                 want.avg, want.last, o_m_tdata, o_m_tlast);
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request.
    initial begin : sink
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int                             sent;
        int                             phase;
        int                             kind;
        int                             total;
        int                             n;
        logic [tfa_pkg::CFG_DATA_W-1:0] fc_word;
        logic [tfa_pkg::CFG_DATA_W-1:0] pc_word;

        // reset values first, then counts of three, two, zero, a pixel count above its limit
        directed_rows = '{
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'h00, 1'b1, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'hFF, 1'b1, '{8'hFF, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'h55, 1'b1, '{8'h55, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'hAA, 1'b1, '{8'hAA, 1'b0}},
            '{ROW_CFG, tfa_pkg::CFG_PIXEL_COUNT, 21'd3,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd10, 1'b1, '{8'd10, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd20, 1'b1, '{8'd20, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd30, 1'b1, '{8'd30, 1'b1}},
            '{ROW_CFG, tfa_pkg::CFG_FRAME_COUNT, 21'd2,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_CFG, tfa_pkg::CFG_PIXEL_COUNT, 21'd2,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'hFF, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'hFF, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'hFF, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_CFG, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd7,  1'b1, '{8'd7,  1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd9,  1'b1, '{8'd9,  1'b1}},
            '{ROW_CFG, tfa_pkg::CFG_PIXEL_COUNT, 21'd0,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd3,  1'b1, '{8'd3,  1'b1}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd4,  1'b1, '{8'd4,  1'b1}},
            '{ROW_CFG, tfa_pkg::CFG_PIXEL_COUNT, CFG_ONES,   8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd5,  1'b1, '{8'd5,  1'b0}},
            '{ROW_CFG, tfa_pkg::CFG_FRAME_COUNT, 21'h1FFE02, 8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_CFG, tfa_pkg::CFG_PIXEL_COUNT, 21'd2,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd100, 1'b0, '{8'h00, 1'b0}},
            '{ROW_CFG, CFG_SPARE_A,              CFG_ONES,   8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd50, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd60, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd70, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd80, 1'b0, '{8'h00, 1'b0}},
            '{ROW_CFG, CFG_SPARE_B,              21'd0,      8'h00, 1'b0, '{8'h00, 1'b0}},
            '{ROW_PIX, tfa_pkg::CFG_FRAME_COUNT, 21'd0,      8'd90, 1'b0, '{8'h00, 1'b0}}
        };

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[r].addr, directed_rows[r].data);
            end else begin
                send_pixel(directed_rows[r].pix, directed_rows[r].known,
                           directed_rows[r].known_word);
            end
        end

        // random phases: new settings, then whole runs, now and then cut short
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            steady  = (phase >= 6 && phase < 12);
            kind    = int'($urandom_range(99));
            fc_word = tfa_pkg::CFG_DATA_W'($urandom_range(1, 6));
            pc_word = tfa_pkg::CFG_DATA_W'($urandom_range(1, 12));
            if (phase == 0) begin
                // full divisor, all white: the largest running sum
                fc_word = tfa_pkg::CFG_DATA_W'(tfa_pkg::MAX_FRAMES);
                pc_word = tfa_pkg::CFG_DATA_W'(1);
            end else if (phase == 1) begin
                fc_word = tfa_pkg::CFG_DATA_W'($urandom_range(tfa_pkg::MAX_FRAMES + 1, 511));
                pc_word = tfa_pkg::CFG_DATA_W'(1);
            end else if (phase == 2) begin
                fc_word = tfa_pkg::CFG_DATA_W'(1);
                pc_word = tfa_pkg::CFG_DATA_W'(64);
            end else if (phase == 3 || kind < 6) begin
                fc_word = tfa_pkg::CFG_DATA_W'($urandom_range(0, 2));
                pc_word = $urandom_range(1) ? tfa_pkg::CFG_DATA_W'(tfa_pkg::MAX_PIXELS)
                        : tfa_pkg::CFG_DATA_W'($urandom_range(tfa_pkg::MAX_PIXELS, 2097151));
            end else if (kind < 14) begin
                if ($urandom_range(1)) fc_word = '0;
                else pc_word = '0;
            end else if (kind < 20) begin
                fc_word = tfa_pkg::CFG_DATA_W'($urandom_range(16, 48));
                pc_word = tfa_pkg::CFG_DATA_W'($urandom_range(1, 2));
            end

            // huge frames never complete: feed only a short stretch of one
            if (eff_pixels(pc_word) > tfa_pkg::PCOUNT_W'(64)) begin
                total = int'($urandom_range(8, 30));
            end else begin
                total = int'(eff_frames(tfa_pkg::FRAMES_W'(fc_word)))
                        * int'(eff_pixels(pc_word))
                        * ((phase < 2) ? 1 : int'($urandom_range(1, 3)));
                if (phase >= 3 && total > 1 && $urandom_range(99) < 15)
                    total = int'($urandom_range(1, total - 1));
            end

            if ($urandom_range(1)) begin
                write_reg(tfa_pkg::CFG_FRAME_COUNT, fc_word);
                write_reg(tfa_pkg::CFG_PIXEL_COUNT, pc_word);
            end else begin
                write_reg(tfa_pkg::CFG_PIXEL_COUNT, pc_word);
                write_reg(tfa_pkg::CFG_FRAME_COUNT, fc_word);
            end
            if ($urandom_range(99) < 10)
                write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                          tfa_pkg::CFG_DATA_W'($urandom));

            // back up the output side so the input stalls
            if (phase == 2) hold_request = 1'b1;
            for (n = 0; n < total; n++) begin
                send_pixel((phase == 0) ? 8'hFF : pick_pixel(), 1'b0, '0);
            end
            sent += total;
            phase++;
        end

        settle();
        if (fail_count == 0 && pending_avgs.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
